FILE: rtl/mfrr_pkg.sv
`default_nettype none

package mfrr_pkg;

  localparam int WORD_W  = 16;
  localparam int INDEX_W = 15;
  localparam int ID_W    = 32;
  localparam int CFG_IDX_W = 1;

  // frame layout
  localparam logic [3:0] FRAME_LEN = 4'd8;
  localparam int WORDS_PER_FRAME   = 3;

  // action codes
  localparam logic [1:0] ACT_START   = 2'd0;
  localparam logic [1:0] ACT_FRAME   = 2'd1;
  localparam logic [1:0] ACT_TIMEOUT = 2'd2;

  // result status codes
  localparam logic [2:0] ST_WORD      = 3'd0;
  localparam logic [2:0] ST_DONE      = 3'd1;
  localparam logic [2:0] ST_TIMEOUT   = 3'd2;
  localparam logic [2:0] ST_BAD_FRAME = 3'd3;
  localparam logic [2:0] ST_FUNC      = 3'd4;
  localparam logic [2:0] ST_SEQ       = 3'd5;
  localparam logic [2:0] ST_OVERFLOW  = 3'd6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ID  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WORDS = 1'd1;

  localparam logic [INDEX_W-1:0] MAX_WORDS_RST = 15'd32767;

  // job queue depth
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // one classified item: up to three words, then optionally an error result
  typedef struct packed {
    logic [WORDS_PER_FRAME-1:0][WORD_W-1:0] words;
    logic [INDEX_W-1:0]                     base;
    logic [1:0]                             count;
    logic                                   fin;
    logic                                   err;
    logic [2:0]                             err_status;
  } job_t;

endpackage

`default_nettype wire

FILE: rtl/mfrr_front.sv
`default_nettype none

module mfrr_front import mfrr_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire logic [1:0]         action,
  input  wire logic [WORD_W-1:0]  expected_function,
  input  wire logic [ID_W-1:0]    frame_id,
  input  wire logic [3:0]         frame_length,
  input  wire logic [WORD_W-1:0]  word_zero,
  input  wire logic [WORD_W-1:0]  word_one,
  input  wire logic [WORD_W-1:0]  word_two,
  input  wire logic [WORD_W-1:0]  word_three,
  input  wire logic [ID_W-1:0]    response_frame_id,
  input  wire logic [INDEX_W-1:0] max_words,
  output logic                    push,
  output job_t                    job
);

  logic               active, active_next;
  logic [WORD_W-1:0]  function_code, function_code_next;
  logic [WORD_W-1:0]  sequence_expected, sequence_expected_next;
  logic [INDEX_W-1:0] words_received, words_received_next;
  logic [INDEX_W-1:0] words_total, words_total_next;
  logic               push_c;

  logic               first;
  logic               id_ok;
  logic               seq_ok;
  logic [INDEX_W-1:0] tot_eff;
  logic [INDEX_W-1:0] r;
  logic [1:0]         n;
  logic               ended;
  logic               fin;
  logic               ovf;
  logic               take;

  always_comb begin
    job                    = '0;
    push_c                 = 1'b0;
    active_next            = active;
    function_code_next     = function_code;
    sequence_expected_next = sequence_expected;
    words_received_next    = words_received;
    words_total_next       = words_total;

    first   = (words_received == '0);
    id_ok   = (frame_id == response_frame_id) && (frame_length == FRAME_LEN);
    seq_ok  = (word_three == sequence_expected);
    tot_eff = first ? word_one[WORD_W-1:1] : words_total;

    // walk the word slots of this frame
    r     = words_received;
    n     = 2'd0;
    ended = 1'b0;
    fin   = 1'b0;
    ovf   = 1'b0;
    for (int i = 0; i < WORDS_PER_FRAME; i++) begin
      take = first ? (i == 0) : (r < tot_eff);
      if (!ended && take) begin
        if (r >= max_words) begin
          ovf   = 1'b1;
          ended = 1'b1;
        end else begin
          n = n + 2'd1;
          if (({1'b0, r} + 16'd1) >= {1'b0, tot_eff}) begin
            fin   = 1'b1;
            ended = 1'b1;
          end
          r = r + 15'd1;
        end
      end
    end

    job.base = words_received;
    if (first) begin
      job.words[0] = word_two;
    end else begin
      job.words[0] = word_zero;
      job.words[1] = word_one;
      job.words[2] = word_two;
    end

    case (action)
      ACT_START: begin
        active_next            = 1'b1;
        function_code_next     = expected_function;
        sequence_expected_next = '0;
        words_received_next    = '0;
        words_total_next       = '0;
      end
      ACT_TIMEOUT: begin
        if (active) begin
          job.err        = 1'b1;
          job.err_status = ST_TIMEOUT;
          push_c         = 1'b1;
          active_next    = 1'b0;
        end
      end
      ACT_FRAME: begin
        if (active) begin
          if (!id_ok) begin
            job.err        = 1'b1;
            job.err_status = ST_BAD_FRAME;
            push_c         = 1'b1;
            active_next    = 1'b0;
          end else if (first && (word_zero != function_code)) begin
            job.err        = 1'b1;
            job.err_status = ST_FUNC;
            push_c         = 1'b1;
            active_next    = 1'b0;
          end else if (!seq_ok) begin
            job.err        = 1'b1;
            job.err_status = ST_SEQ;
            push_c         = 1'b1;
            active_next    = 1'b0;
          end else begin
            job.count              = n;
            job.fin                = fin;
            job.err                = ovf;
            job.err_status         = ST_OVERFLOW;
            push_c                 = (n != 2'd0) || ovf;
            words_received_next    = r;
            sequence_expected_next = sequence_expected + 16'd1;
            if (first) begin
              words_total_next = tot_eff;
            end
            if (ovf || fin) begin
              active_next = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign push = accept && push_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      active            <= 1'b0;
      function_code     <= '0;
      sequence_expected <= '0;
      words_received    <= '0;
      words_total       <= '0;
    end else if (accept) begin
      active            <= active_next;
      function_code     <= function_code_next;
      sequence_expected <= sequence_expected_next;
      words_received    <= words_received_next;
      words_total       <= words_total_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mfrr_queue.sv
`default_nettype none

module mfrr_queue import mfrr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output logic      full,
  output logic      head_valid,
  output job_t      head
);

  job_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wp;
  logic [QPTR_W-1:0] rp;
  logic [QCNT_W-1:0] cnt;

  assign full       = (cnt == QCNT_W'(QDEPTH));
  assign head_valid = (cnt != '0);
  assign head       = entries[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wp] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mfrr_back.sv
`default_nettype none

module mfrr_back import mfrr_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                head_valid,
  input  wire job_t                head,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [WORD_W-1:0]        data_word,
  output logic [INDEX_W-1:0]       word_index,
  output logic [2:0]               status,
  output logic                     last
);

  logic [1:0]         k;
  logic [1:0]         nres;
  logic               load;
  logic               is_word;
  logic               end_res;
  logic               word_fin;
  logic [WORD_W-1:0]  r_data;
  logic [INDEX_W-1:0] r_index;
  logic [2:0]         r_status;
  logic               r_last;

  always_comb begin
    nres     = head.count + {1'b0, head.err};
    is_word  = (k < head.count);
    end_res  = ((k + 2'd1) == nres);
    word_fin = head.fin && ((k + 2'd1) == head.count);
    load     = head_valid && (!out_valid || out_ready);
    pop      = load && end_res;
    if (is_word) begin
      r_data   = head.words[k];
      r_index  = head.base + {{(INDEX_W-2){1'b0}}, k};
      r_status = word_fin ? ST_DONE : ST_WORD;
      r_last   = word_fin;
    end else begin
      r_data   = '0;
      r_index  = head.base + {{(INDEX_W-2){1'b0}}, head.count};
      r_status = head.err_status;
      r_last   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        k         <= end_res ? 2'd0 : k + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_word  <= r_data;
      word_index <= r_index;
      status     <= r_status;
      last       <= r_last;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/multi_frame_read_response_reassembler.sv
// Multi-frame read response reassembler.
// Input channel (in_valid/in_ready): one item per action. A start item arms
// a transaction with the expected function code; a frame item carries one
// received frame (identifier, length code, four 16-bit words, the fourth
// being the sequence number); a timeout item ends the transaction with error.
// Output channel (out_valid/out_ready): one result per word, with its index;
// the final word carries status success and last. Any error gives a single
// result with data zero, the error status and last set.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 is the
// response frame identifier, index 1 the word capacity. Always ready.
// Timing: the front classifies an item and updates the transaction state in
// the cycle it is accepted; the resulting job enters a two-entry queue. The
// back drains one result per cycle while out_ready allows; each goes via the
// queue entry and the output register. A three-word job holds the queue head
// to its third result. in_ready drops only when the queue holds two jobs.
// Reset: synchronous; clears transaction state, the queue and out_valid, and
// loads the register defaults (identifier 0, capacity 32767).
// A stalled receiver holds the output register; the queue absorbs up to two
// more jobs before the input is back-pressured.
`default_nettype none

module multi_frame_read_response_reassembler import mfrr_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           action,
  input  wire logic [WORD_W-1:0]    expected_function,
  input  wire logic [ID_W-1:0]      frame_id,
  input  wire logic [3:0]           frame_length,
  input  wire logic [WORD_W-1:0]    word_zero,
  input  wire logic [WORD_W-1:0]    word_one,
  input  wire logic [WORD_W-1:0]    word_two,
  input  wire logic [WORD_W-1:0]    word_three,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [WORD_W-1:0]         data_word,
  output logic [INDEX_W-1:0]        word_index,
  output logic [2:0]                status,
  output logic                      last,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ID_W-1:0]      cfg_data
);

  logic [ID_W-1:0]    response_frame_id;
  logic [INDEX_W-1:0] max_words;

  logic accept;
  logic push;
  job_t push_job;
  logic q_full;
  logic head_valid;
  job_t head;
  logic pop;

  // config registers, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      response_frame_id <= '0;
      max_words         <= MAX_WORDS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FRAME_ID:  response_frame_id <= cfg_data;
        CFG_MAX_WORDS: max_words         <= cfg_data[INDEX_W-1:0];
        default: ;
      endcase
    end
  end

  // front takes items whenever the queue has room
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  mfrr_front u_front (
    .clk               (clk),
    .rst               (rst),
    .accept            (accept),
    .action            (action),
    .expected_function (expected_function),
    .frame_id          (frame_id),
    .frame_length      (frame_length),
    .word_zero         (word_zero),
    .word_one          (word_one),
    .word_two          (word_two),
    .word_three        (word_three),
    .response_frame_id (response_frame_id),
    .max_words         (max_words),
    .push              (push),
    .job               (push_job)
  );

  mfrr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // back drains one result per cycle into the output register unless stalled
  mfrr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .data_word  (data_word),
    .word_index (word_index),
    .status     (status),
    .last       (last)
  );

endmodule

`default_nettype wire

FILE: rtl/mfrr_checker.sv
`default_nettype none

module mfrr_checker import mfrr_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [WORD_W-1:0]  data_word,
  input wire logic [INDEX_W-1:0] word_index,
  input wire logic [2:0]         status,
  input wire logic               last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_word) &&
      $stable(word_index) && $stable(status) && $stable(last))
    else $error("output item changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  a_err_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_WORD) && (status != ST_DONE) |->
      last && (data_word == '0))
    else $error("error result without last or with data");

  a_last_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((status == ST_WORD) || (status == ST_DONE)) |->
      (last == (status == ST_DONE)))
    else $error("last flag disagrees with word status");

  // a restart mid-response begins again at index zero
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last ##1 out_valid |->
      (word_index == $past(word_index) + 15'd1) || (word_index == '0))
    else $error("word index did not advance within a response");

endmodule

bind multi_frame_read_response_reassembler mfrr_checker u_mfrr_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .data_word  (data_word),
  .word_index (word_index),
  .status     (status),
  .last       (last)
);

`default_nettype wire

FILE: tb/sv/reassembly_checker.sv
`timescale 1ns / 1ps

module reassembly_checker import mfrr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [1:0]           action,
  input  logic [WORD_W-1:0]    expected_function,
  input  logic [ID_W-1:0]      frame_id,
  input  logic [3:0]           frame_length,
  input  logic [WORD_W-1:0]    word_zero,
  input  logic [WORD_W-1:0]    word_one,
  input  logic [WORD_W-1:0]    word_two,
  input  logic [WORD_W-1:0]    word_three,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [WORD_W-1:0]    data_word,
  input  logic [INDEX_W-1:0]   word_index,
  input  logic [2:0]           status,
  input  logic                 last,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ID_W-1:0]      cfg_data,
  output int                   mismatches,
  output int                   outstanding
);

  typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic [INDEX_W-1:0] index;
    logic [2:0]         code;
    logic               fin;
  } word_result_t;

  word_result_t results_due[$];

  // register copies
  logic [ID_W-1:0]    resp_id;
  logic [INDEX_W-1:0] capacity;

  // transaction state
  logic               armed;
  logic [WORD_W-1:0]  func_code;
  logic [WORD_W-1:0]  seq_due;
  logic [INDEX_W-1:0] words_done;
  logic [INDEX_W-1:0] words_total;

  task automatic post(input logic [WORD_W-1:0] w, input logic [2:0] code, input logic fin);
    word_result_t r;
    r.word  = w;
    r.index = words_done;
    r.code  = code;
    r.fin   = fin;
    results_due.push_back(r);
  endtask

  task automatic close_with(input logic [2:0] code);
    post('0, code, 1'b1);
    armed = 1'b0;
  endtask

  task automatic take_word(input logic [WORD_W-1:0] w, inout bit ended);
    bit fin;
    if (words_done >= capacity) begin
      close_with(ST_OVERFLOW);
      ended = 1'b1;
    end else begin
      fin = (int'(words_done) + 1 >= int'(words_total));
      post(w, fin ? ST_DONE : ST_WORD, fin);
      words_done = words_done + 1'b1;
      if (fin) begin
        armed = 1'b0;
        ended = 1'b1;
      end
    end
  endtask

  task automatic reassemble(input logic [1:0] act, input logic [WORD_W-1:0] func,
                            input logic [ID_W-1:0] fid, input logic [3:0] flen,
                            input logic [WORD_W-1:0] w0, w1, w2, w3);
    logic [WORD_W-1:0] data [WORDS_PER_FRAME];
    bit ended;
    data[0] = w0;
    data[1] = w1;
    data[2] = w2;
    ended = 1'b0;
    case (act)
      ACT_START: begin
        armed       = 1'b1;
        func_code   = func;
        seq_due     = '0;
        words_done  = '0;
        words_total = '0;
      end
      ACT_TIMEOUT: if (armed) begin
        close_with(ST_TIMEOUT);
      end
      ACT_FRAME: if (armed) begin
        // id/length, then function (first frame only), then sequence
        if (fid != resp_id || flen != FRAME_LEN) begin
          close_with(ST_BAD_FRAME);
        end else if (words_done == '0 && w0 != func_code) begin
          close_with(ST_FUNC);
        end else if (w3 != seq_due) begin
          close_with(ST_SEQ);
        end else begin
          if (words_done == '0) begin
            words_total = w1[WORD_W-1:1];
            take_word(w2, ended);
          end else begin
            for (int i = 0; i < WORDS_PER_FRAME; i++)
              if (!ended && words_done < words_total) take_word(data[i], ended);
          end
          seq_due = seq_due + 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    word_result_t due;
    if (rst) begin
      resp_id     = '0;
      capacity    = MAX_WORDS_RST;
      armed       = 1'b0;
      func_code   = '0;
      seq_due     = '0;
      words_done  = '0;
      words_total = '0;
      results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FRAME_ID:  resp_id  = cfg_data;
          CFG_MAX_WORDS: capacity = cfg_data[INDEX_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        reassemble(action, expected_function, frame_id, frame_length,
                   word_zero, word_one, word_two, word_three);
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $error("unexpected result: data_word %h word_index %0d status %0d last %0b",
                 data_word, word_index, status, last);
          mismatches++;
        end else begin
          due = results_due.pop_front();
          if (data_word !== due.word) begin
            $error("data_word: expected %h, got %h", due.word, data_word);
            mismatches++;
          end
          if (word_index !== due.index) begin
            $error("word_index: expected %0d, got %0d", due.index, word_index);
            mismatches++;
          end
          if (status !== due.code) begin
            $error("status: expected %0d, got %0d", due.code, status);
            mismatches++;
          end
          if (last !== due.fin) begin
            $error("last: expected %0b, got %0b", due.fin, last);
            mismatches++;
          end
        end
      end
    end
    outstanding = results_due.size();
  end

endmodule

FILE: tb/sv/tb_multi_frame_read_response_reassembler.sv
`timescale 1ns / 1ps

module tb_multi_frame_read_response_reassembler;
  import mfrr_pkg::*;

  // action code 3 has no meaning to the block; it must be ignored
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam int ITEM_TARGET   = 280;
  localparam int PHASE_ITEMS   = 30;
  localparam int HOLD_CYCLES   = 200;   // long receiver hold-off
  localparam int SETTLE_CYCLES = 8;     // item-to-result latency plus queue slack
  localparam int QUIET_LIMIT   = 2000;  // cycles without any handshake
  localparam int MAX_FRAMES    = 6;     // huge byte counts get cut short
  localparam int NO_FAULT      = -1;

  // ways a well-formed exchange gets broken
  typedef enum int {
    FLT_ID, FLT_LEN, FLT_FUNC, FLT_SEQ, FLT_TIMEOUT, FLT_RESTART, FLT_UNUSED
  } fault_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           action;
  logic [WORD_W-1:0]    expected_function;
  logic [ID_W-1:0]      frame_id;
  logic [3:0]           frame_length;
  logic [WORD_W-1:0]    word_zero;
  logic [WORD_W-1:0]    word_one;
  logic [WORD_W-1:0]    word_two;
  logic [WORD_W-1:0]    word_three;
  logic                 out_valid;
  logic                 out_ready;
  logic [WORD_W-1:0]    data_word;
  logic [INDEX_W-1:0]   word_index;
  logic [2:0]           status;
  logic                 last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ID_W-1:0]      cfg_data;

  int mismatches;
  int outstanding;

  // idling knobs, percent per cycle
  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  bit hold_request  = 1'b0;

  // identifier currently programmed, used to build good frames
  logic [ID_W-1:0] resp_id;
  int items_sent   = 0;
  int quiet_cycles = 0;

  multi_frame_read_response_reassembler uut (.*);

  reassembly_checker checker_i (.*);

  always #1 clk = ~clk;

  // Watchdog: any accepted item on any channel restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: random stalls, or one long hold-off when asked. The hold-off
  // is timed here so the sender keeps offering items and the block backs up.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  // One item on the input channel. Valid is dropped only for idle cycles,
  // so back-to-back items keep it high across the accepting edge.
  task automatic send_item(input logic [1:0] act, input logic [WORD_W-1:0] func,
                           input logic [ID_W-1:0] fid, input logic [3:0] flen,
                           input logic [WORD_W-1:0] w0, w1, w2, w3);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    action            <= act;
    expected_function <= func;
    frame_id          <= fid;
    frame_length      <= flen;
    word_zero         <= w0;
    word_one          <= w1;
    word_two          <= w2;
    word_three        <= w3;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // fields that the action does not use are left random
  task automatic send_start(input logic [WORD_W-1:0] func);
    send_item(ACT_START, func, $urandom, 4'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom));
  endtask

  task automatic send_ctl(input logic [1:0] act);
    send_item(act, 16'($urandom), $urandom, 4'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom));
  endtask

  // well-formed frame: programmed id, length 8
  task automatic send_frame(input logic [WORD_W-1:0] w0, w1, w2, w3);
    send_item(ACT_FRAME, 16'($urandom), resp_id, FRAME_LEN, w0, w1, w2, w3);
  endtask

  // Drop valid and wait until every expected result is back, then a few
  // more cycles in case the last item produced nothing but is still in flight.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ID_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == CFG_FRAME_ID) resp_id = value;
  endtask

  // registers change only with the block drained
  task automatic configure(input logic [ID_W-1:0] id, input logic [ID_W-1:0] cap);
    settle();
    write_reg(CFG_FRAME_ID, id);
    write_reg(CFG_MAX_WORDS, cap);
  endtask

  // Start, then the frames for byte_count, optionally broken at one frame.
  // Frames after a fault are still sent; the block must ignore or reject them.
  task automatic run_exchange(input logic [WORD_W-1:0] byte_count, input int fault_at,
                              input fault_t fault);
    logic [WORD_W-1:0] func;
    logic [WORD_W-1:0] w [4];
    logic [ID_W-1:0]   fid;
    logic [3:0]        flen;
    int                n_words;
    int                frames;
    func    = 16'($urandom);
    n_words = byte_count >> 1;
    // first frame holds one word, later frames three each
    frames  = (n_words <= 1) ? 1 : 1 + (n_words + 1) / 3;
    if (frames > MAX_FRAMES) frames = MAX_FRAMES;
    send_start(func);
    for (int f = 0; f < frames; f++) begin
      w[0] = (f == 0) ? func : 16'($urandom);
      w[1] = (f == 0) ? byte_count : 16'($urandom);
      w[2] = 16'($urandom);
      w[3] = 16'(f);
      fid  = resp_id;
      flen = FRAME_LEN;
      if (f == fault_at) begin
        case (fault)
          FLT_ID:   fid = resp_id ^ (32'd1 << $urandom_range(31));
          FLT_LEN: begin
            flen = 4'($urandom_range(14));
            if (flen >= FRAME_LEN) flen = flen + 1'b1;
          end
          FLT_FUNC:    w[0] = w[0] ^ 16'($urandom_range(1, 65535));
          FLT_SEQ:     w[3] = w[3] + 16'($urandom_range(1, 65535));
          FLT_TIMEOUT: send_ctl(ACT_TIMEOUT);
          FLT_RESTART: send_start(func);
          default:     send_ctl(ACT_NONE);
        endcase
      end
      send_item(ACT_FRAME, 16'($urandom), fid, flen, w[0], w[1], w[2], w[3]);
    end
  endtask

  // Mostly well-formed exchanges with random content; the rest is noise.
  task automatic random_exchange();
    logic [WORD_W-1:0] byte_count;
    int                pick;
    int                fault_at;
    pick = $urandom_range(99);
    if (pick < 75) begin
      // a few huge word counts (cut short), otherwise up to a dozen words
      if (pick < 4)
        byte_count = 16'($urandom);
      else
        byte_count = 16'($urandom_range(0, 25));
      fault_at = ($urandom_range(9) < 3) ? int'($urandom_range(0, 3)) : NO_FAULT;
      run_exchange(byte_count, fault_at, fault_t'($urandom_range(int'(FLT_UNUSED))));
    end else begin
      send_item(2'($urandom_range(3)), 16'($urandom),
                $urandom_range(1) ? resp_id : ID_W'($urandom),
                $urandom_range(1) ? FRAME_LEN : 4'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom),
                $urandom_range(1) ? 16'($urandom_range(3)) : 16'($urandom));
    end
  endtask

  initial begin
    int phase_end;
    rst               <= 1'b1;
    in_valid          <= 1'b0;
    action            <= ACT_START;
    expected_function <= '0;
    frame_id          <= '0;
    frame_length      <= '0;
    word_zero         <= '0;
    word_one          <= '0;
    word_two          <= '0;
    word_three        <= '0;
    cfg_valid         <= 1'b0;
    cfg_index         <= CFG_FRAME_ID;
    cfg_data          <= '0;
    resp_id = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // ---- directed, register defaults (id 0, full capacity) ----
    // nothing armed: timeout and the unused code are dropped
    send_ctl(ACT_TIMEOUT);
    send_ctl(ACT_NONE);
    // start while armed restarts; unused code while armed is dropped
    send_start(16'hFFFF);
    send_start(16'h1234);
    send_ctl(ACT_NONE);
    // byte count 0: the single word of the first frame is the final word
    send_frame(16'h1234, 16'h0000, 16'hFFFF, 16'h0000);
    // seven words over three frames, last one marked done
    send_start(16'hA5A5);
    send_frame(16'hA5A5, 16'd14, 16'h8001, 16'h0000);
    send_frame(16'hFFFF, 16'h0000, 16'h7FFE, 16'd1);
    send_frame(16'h5A5A, 16'h0001, 16'hFFFE, 16'd2);
    // bad id with bad function: the id check wins
    send_start(16'h0001);
    send_item(ACT_FRAME, '0, 32'hFFFF_FFFF, FRAME_LEN, 16'h0002, 16'd4, '0, '0);
    // length extremes
    send_start(16'h0001);
    send_item(ACT_FRAME, '0, resp_id, 4'hF, 16'h0001, 16'd4, '0, '0);
    send_start(16'h0001);
    send_item(ACT_FRAME, '0, resp_id, 4'h0, 16'h0001, 16'd4, '0, '0);
    // bad function with bad sequence: function wins
    send_start(16'h0001);
    send_frame(16'h0002, 16'd4, 16'h0000, 16'd7);
    // full byte count, then a sequence error mid-transaction
    send_start(16'h7777);
    send_frame(16'h7777, 16'hFFFF, 16'h1111, 16'd0);
    send_frame(16'h0001, 16'h0002, 16'h0003, 16'hFFFF);
    // timeout after one word
    send_start(16'h2222);
    send_frame(16'h2222, 16'd20, 16'h3333, 16'd0);
    send_ctl(ACT_TIMEOUT);

    // zero capacity: first word overflows
    configure(32'h0000_0000, 32'd0);
    send_start(16'h4321);
    send_frame(16'h4321, 16'd8, 16'hBEEF, 16'd0);
    // capacity 2: one word fits from the second frame, then overflow
    configure(32'hFFFF_FFFF, 32'd2);
    send_start(16'h0F0F);
    send_frame(16'h0F0F, 16'd10, 16'h1001, 16'd0);
    send_frame(16'h2002, 16'h3003, 16'h4004, 16'd1);

    // ---- random phases: register setting and idling mode rotate ----
    for (int p = 0; items_sent < ITEM_TARGET; p++) begin
      case (p % 8)
        0: configure(32'hFFFF_FFFF, 32'd32767);
        1: configure($urandom, 32'd1);
        2: configure($urandom, 32'd0);
        3: configure(32'h8000_0000 | $urandom, 32'($urandom_range(2, 6)));
        4: configure($urandom, 32'($urandom_range(1, 32767)));
        5: configure($urandom, 32'($urandom_range(3, 20)));
        6: configure($urandom, 32'd32767);
        default: configure(32'h0000_0000, 32'd2);
      endcase
      case (p % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 45; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 45; end
        default: begin in_idle_pct = 23; out_stall_pct = 23; end
      endcase
      // long receiver hold-off while the sender keeps pushing
      if (p == 4) hold_request = 1'b1;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) random_exchange();
    end

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/mfrr_pkg.sv
rtl/mfrr_front.sv
rtl/mfrr_queue.sv
rtl/mfrr_back.sv
rtl/multi_frame_read_response_reassembler.sv
rtl/mfrr_checker.sv
tb/sv/reassembly_checker.sv
tb/sv/tb_multi_frame_read_response_reassembler.sv
